/* hdl/stunp_pkg.sv */
// ----------------------------------------------------------------------------
// stunp_pkg
// Shared constants and types for the STUN binding response parser.
// ----------------------------------------------------------------------------
package stunp_pkg;

  localparam logic [31:0] COOKIE          = 32'h2112A442;
  localparam logic [15:0] TYPE_RESPONSE   = 16'h0101;
  localparam logic [15:0] ATTR_MAPPED     = 16'h0001;
  localparam logic [15:0] ATTR_XOR_MAPPED = 16'h0020;
  localparam logic [7:0]  FAM_V4          = 8'h01;
  localparam logic [7:0]  FAM_V6          = 8'h02;
  localparam int unsigned HDR_LEN         = 20;
  localparam logic [16:0] POS_MAX         = '1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
  localparam logic [2:0] ST_BAD_COOK  = 3'd3;
  localparam logic [2:0] ST_BAD_TRANS = 3'd4;
  localparam logic [2:0] ST_NO_ADDR   = 3'd5;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        family;
    logic [15:0] port;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } result_t;

endpackage

/* hdl/stun_binding_response_parser_unit.sv */
// path: an accepted byte is held in the input register and parsed from there; for a
// last byte the parser loads the result item into the result register
// throughput: one byte per cycle; a last byte waits in the input register only
// while the previous result item is still stalled at the output
// reset: rst_ni clears the parser state, the valid flags and the transaction ID register to zero
// ----------------------------------------------------------------------------
// stun_binding_response_parser_unit
// STUN binding response parser: header check, attribute walk, mapped address.
// ----------------------------------------------------------------------------
module stun_binding_response_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        addr_family_o,
  output logic [15:0] mapped_port_o,
  output logic [63:0] addr_high_o,
  output logic [63:0] addr_low_o
);
  import stunp_pkg::*;

  item_t   item;
  logic    out_blocked;
  logic    res_load;
  result_t res_d;
  result_t res_q;

  stunp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .out_blocked_i(out_blocked),
    .item_o       (item)
  );

  stunp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item),
    .res_load_o (res_load),
    .res_o      (res_d)
  );

  stunp_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_load_i   (res_load),
    .res_i        (res_d),
    .out_blocked_o(out_blocked),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res_q)
  );

  assign status_o      = res_q.status;
  assign addr_family_o = res_q.family;
  assign mapped_port_o = res_q.port;
  assign addr_high_o   = res_q.addr_high;
  assign addr_low_o    = res_q.addr_low;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> !addr_family_o && mapped_port_o == '0
      && addr_high_o == '0 && addr_low_o == '0)
    else $error("failed result carries address data");

  a_v4_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK && !addr_family_o |->
      addr_high_o == '0 && addr_low_o[63:32] == '0)
    else $error("ipv4 result wider than 32 bits");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_NO_ADDR)
    else $error("status code out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !res_load)
    else $error("result register overwritten while stalled");

endmodule

/* hdl/stunp_in_reg.sv */
// ----------------------------------------------------------------------------
// stunp_in_reg
// Input register; holds a last item while the result register is stalled.
// ----------------------------------------------------------------------------
module stunp_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      data_byte_i,
  input  logic            last_byte_i,
  input  logic            out_blocked_i,
  output stunp_pkg::item_t item_o
);
  import stunp_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       last_q;
  logic       hold;
  logic       accept;

  assign hold       = valid_q && last_q && out_blocked_i;
  assign in_stall_o = hold;
  assign accept     = in_valid_i && !hold;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (!hold) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  assign item_o.valid = valid_q && !hold;
  assign item_o.data  = data_q;
  assign item_o.last  = last_q;

endmodule

/* hdl/stunp_parser.sv */
// ----------------------------------------------------------------------------
// stunp_parser
// Per-byte header check, attribute walk and address capture.
// ----------------------------------------------------------------------------
module stunp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  input  stunp_pkg::item_t  item_i,
  output logic              res_load_o,
  output stunp_pkg::result_t res_o
);
  import stunp_pkg::*;

  logic [31:0] tid_cfg_q;
  logic [16:0] pos_q, pos_d;
  logic [15:0] msg_len_q, msg_len_d;
  logic [2:0]  hdr_err_q, hdr_err_d;
  logic [31:0] tid_first_q, tid_first_d;
  logic [63:0] tid_rest_q, tid_rest_d;
  logic [15:0] attr_type_q, attr_type_d;
  logic [15:0] attr_len_q, attr_len_d;
  logic [15:0] attr_cnt_q, attr_cnt_d;
  logic [7:0]  fam_q, fam_d;
  logic [15:0] port_q, port_d;
  logic [63:0] addr_lo_q, addr_lo_d;
  logic [63:0] addr_hi_q, addr_hi_d;
  logic        found_q, found_d;
  logic        stopped_q, stopped_d;
  result_t     res_d;
  logic        res_load_d;

  always_comb begin
    logic [7:0]  b;
    logic [17:0] p18;
    logic [17:0] p_inc;
    logic [17:0] msg_end;
    logic [17:0] c_next;
    logic [17:0] pad;
    logic [15:0] v;
    logic [15:0] new_len;
    logic [2:0]  err;
    logic        relevant;
    logic        done;
    logic [2:0]  st;

    pos_d       = pos_q;
    msg_len_d   = msg_len_q;
    hdr_err_d   = hdr_err_q;
    tid_first_d = tid_first_q;
    tid_rest_d  = tid_rest_q;
    attr_type_d = attr_type_q;
    attr_len_d  = attr_len_q;
    attr_cnt_d  = attr_cnt_q;
    fam_d       = fam_q;
    port_d      = port_q;
    addr_lo_d   = addr_lo_q;
    addr_hi_d   = addr_hi_q;
    found_d     = found_q;
    stopped_d   = stopped_q;
    res_d       = '0;
    res_load_d  = 1'b0;

    b        = item_i.data;
    p18      = {1'b0, pos_q};
    p_inc    = p18 + 18'd1;
    msg_end  = 18'(HDR_LEN) + {2'b00, msg_len_q};
    c_next   = {2'b00, attr_cnt_q} + 18'd1;
    pad      = '0;
    v        = attr_cnt_q - 16'd4;
    new_len  = {attr_len_q[15:8], b};
    err      = ST_OK;
    relevant = 1'b0;
    done     = 1'b0;
    st       = ST_OK;

    if (item_i.valid) begin
      if (p18 < 18'(HDR_LEN)) begin
        // header bytes
        if (pos_q[4:0] <= 5'd1) begin
          if (b != (pos_q[0] ? TYPE_RESPONSE[7:0] : TYPE_RESPONSE[15:8])) begin
            err = ST_BAD_TYPE;
          end
        end else if (pos_q[4:0] == 5'd2) begin
          msg_len_d = {b, 8'h00};
        end else if (pos_q[4:0] == 5'd3) begin
          msg_len_d = {msg_len_q[15:8], b};
        end else if (pos_q[4:0] <= 5'd7) begin
          if (b != 8'(COOKIE >> {~pos_q[1:0], 3'b000})) begin
            err = ST_BAD_COOK;
          end
        end else if (pos_q[4:0] <= 5'd11) begin
          if (b != 8'(tid_cfg_q >> {~pos_q[1:0], 3'b000})) begin
            err = ST_BAD_TRANS;
          end
          tid_first_d = {tid_first_q[23:0], b};
        end else begin
          tid_rest_d = {tid_rest_q[55:0], b};
        end
        if (hdr_err_q == ST_OK && err != ST_OK) begin
          hdr_err_d = err;
        end
      end else if (p18 < msg_end && !stopped_q && !found_q) begin
        // attribute walk
        if (attr_cnt_q == 16'd0) begin
          if (p18 + 18'd4 > msg_end) begin
            stopped_d = 1'b1;
            done      = 1'b1;
          end else begin
            attr_type_d = {b, 8'h00};
            fam_d       = '0;
            port_d      = '0;
            addr_lo_d   = '0;
            addr_hi_d   = '0;
          end
        end else if (attr_cnt_q == 16'd1) begin
          attr_type_d = {attr_type_q[15:8], b};
        end else if (attr_cnt_q == 16'd2) begin
          attr_len_d = {b, 8'h00};
        end else if (attr_cnt_q == 16'd3) begin
          attr_len_d = new_len;
          if (p_inc + {2'b00, new_len} > msg_end) begin
            stopped_d = 1'b1;
            done      = 1'b1;
          end
        end else begin
          relevant = (attr_type_q == ATTR_XOR_MAPPED || attr_type_q == ATTR_MAPPED)
                     && attr_len_q >= 16'd8;
          if (relevant) begin
            if (v == 16'd1) begin
              fam_d = b;
            end else if (v == 16'd2 || v == 16'd3) begin
              port_d = {port_q[7:0], b};
            end else if (v >= 16'd4 && v <= 16'd19) begin
              {addr_hi_d, addr_lo_d} = {addr_hi_q[55:0], addr_lo_q, b};
            end
            if ((v == 16'd7 && fam_q == FAM_V4) ||
                (v == 16'd19 && fam_q == FAM_V6 && attr_len_q >= 16'd20)) begin
              if (attr_type_q == ATTR_XOR_MAPPED) begin
                port_d = port_d ^ COOKIE[31:16];
                if (fam_q == FAM_V4) begin
                  addr_lo_d = addr_lo_d ^ {32'h0, COOKIE};
                end else begin
                  addr_hi_d = addr_hi_d ^ {COOKIE, tid_first_q};
                  addr_lo_d = addr_lo_d ^ tid_rest_q;
                end
              end
              found_d = 1'b1;
              done    = 1'b1;
            end
          end
        end
        if (!done) begin
          pad = ({2'b00, attr_len_d} + 18'd3) & ~18'd3;
          if (c_next >= 18'd4 && c_next >= 18'd4 + pad) begin
            attr_cnt_d = '0;
          end else begin
            attr_cnt_d = c_next[15:0];
          end
        end
      end

      if (pos_q != POS_MAX) begin
        pos_d = p_inc[16:0];
      end

      if (item_i.last) begin
        msg_end = 18'(HDR_LEN) + {2'b00, msg_len_d};
        if (p_inc < 18'(HDR_LEN)) begin
          st = ST_SHORT;
        end else if (hdr_err_d != ST_OK) begin
          st = hdr_err_d;
        end else if (found_d) begin
          st = ST_OK;
        end else if (!stopped_d && p_inc < msg_end) begin
          st = ST_SHORT;
        end else begin
          st = ST_NO_ADDR;
        end
        res_load_d   = 1'b1;
        res_d.status = st;
        if (st == ST_OK) begin
          res_d.family    = (fam_d == FAM_V6);
          res_d.port      = port_d;
          res_d.addr_high = addr_hi_d;
          res_d.addr_low  = addr_lo_d;
        end
        pos_d       = '0;
        msg_len_d   = '0;
        hdr_err_d   = ST_OK;
        tid_first_d = '0;
        tid_rest_d  = '0;
        attr_type_d = '0;
        attr_len_d  = '0;
        attr_cnt_d  = '0;
        fam_d       = '0;
        port_d      = '0;
        addr_lo_d   = '0;
        addr_hi_d   = '0;
        found_d     = 1'b0;
        stopped_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tid_cfg_q   <= '0;
      pos_q       <= '0;
      msg_len_q   <= '0;
      hdr_err_q   <= ST_OK;
      tid_first_q <= '0;
      tid_rest_q  <= '0;
      attr_type_q <= '0;
      attr_len_q  <= '0;
      attr_cnt_q  <= '0;
      fam_q       <= '0;
      port_q      <= '0;
      addr_lo_q   <= '0;
      addr_hi_q   <= '0;
      found_q     <= 1'b0;
      stopped_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tid_cfg_q <= cfg_wdata_i;
      end
      pos_q       <= pos_d;
      msg_len_q   <= msg_len_d;
      hdr_err_q   <= hdr_err_d;
      tid_first_q <= tid_first_d;
      tid_rest_q  <= tid_rest_d;
      attr_type_q <= attr_type_d;
      attr_len_q  <= attr_len_d;
      attr_cnt_q  <= attr_cnt_d;
      fam_q       <= fam_d;
      port_q      <= port_d;
      addr_lo_q   <= addr_lo_d;
      addr_hi_q   <= addr_hi_d;
      found_q     <= found_d;
      stopped_q   <= stopped_d;
    end
  end

  assign res_load_o = res_load_d;
  assign res_o      = res_d;

  a_packet_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.last |=> pos_q == '0 && !found_q && !stopped_q)
    else $error("parser state not cleared after last item");

  a_found_xor_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(found_q && stopped_q))
    else $error("address found and walk stopped together");

endmodule

/* hdl/stunp_out_reg.sv */
// ----------------------------------------------------------------------------
// stunp_out_reg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module stunp_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_load_i,
  input  stunp_pkg::result_t res_i,
  output logic               out_blocked_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output stunp_pkg::result_t res_o
);
  import stunp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (res_load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load_i) begin
      res_q <= res_i;
    end
  end

  assign out_blocked_o = valid_q && out_stall_i;
  assign out_valid_o   = valid_q;
  assign res_o         = res_q;

endmodule
